// ----- hdl/msr_pkg.sv -----
// Shared types, codes and helpers for the motor speed ramp and stall guard.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msr_pkg;

  localparam int SpeedW  = 16;
  localparam int RemW    = 7;
  localparam int StepW   = 10;
  localparam int CfgIdxW = 3;

  localparam logic [16:0] RampScale = 17'd100;
  localparam int          RecipShift = 24;
  localparam logic [34:0] RecipMul  = 35'd167773;

  localparam logic [1:0] WS_IDLE    = 2'd0;
  localparam logic [1:0] WS_STOP    = 2'd1;
  localparam logic [1:0] WS_FORWARD = 2'd2;
  localparam logic [1:0] WS_REVERSE = 2'd3;

  localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_CODE_ERR  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ACCEL_RATE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECEL_RATE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_LIMIT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STALL_TIME  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BOUNCE_TIME = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STALL_EN    = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RUN  = 3'b010,
    MODE_ERR  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [SpeedW-1:0] accel_rate;
    logic [SpeedW-1:0] decel_rate;
    logic [SpeedW-1:0] low_speed_limit;
    logic [SpeedW-1:0] stall_timeout;
    logic [SpeedW-1:0] bounce_timeout;
    logic              stall_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SpeedW-1:0] reference_speed;
    logic              drive_enable;
    logic              regulator_clear;
    logic              stall_fault;
  } res_t;

  // sum / 100 by reciprocal multiply; exact for sums below 102400
  function automatic logic [StepW-1:0] quot100(input logic [16:0] sum);
    logic [34:0] prod;
    prod = 35'(sum) * RecipMul;
    return prod[RecipShift+StepW-1:RecipShift];
  endfunction

  function automatic logic [RemW-1:0] rem100(input logic [16:0] sum,
                                             input logic [StepW-1:0] q);
    logic [16:0] diff;
    diff = sum - 17'(q) * RampScale;
    return diff[RemW-1:0];
  endfunction

endpackage

// ----- hdl/msr_ramp.sv -----
// Ramp step for the reference speed with hundredths remainders.
// Depends on msr_pkg.
`timescale 1ns / 1ps

module msr_ramp import msr_pkg::*; (
  input  logic [SpeedW-1:0] ref_speed,
  input  logic [SpeedW-1:0] target,
  input  logic [RemW-1:0]   accel_rem,
  input  logic [RemW-1:0]   decel_rem,
  input  logic [SpeedW-1:0] accel_rate,
  input  logic [SpeedW-1:0] decel_rate,
  output logic [SpeedW-1:0] ref_speed_next,
  output logic [RemW-1:0]   accel_rem_next,
  output logic [RemW-1:0]   decel_rem_next
);

  logic [16:0]       rem_sum;
  logic [StepW-1:0]  step;
  logic [16:0]       up_speed;
  logic              accel;
  logic              decel;

  assign accel   = target > ref_speed;
  assign decel   = target < ref_speed;
  assign rem_sum = accel ? (17'(accel_rem) + 17'(accel_rate))
                         : (17'(decel_rem) + 17'(decel_rate));
  assign step     = quot100(rem_sum);
  assign up_speed = 17'(ref_speed) + 17'(step);

  always_comb begin
    ref_speed_next = ref_speed;
    accel_rem_next = accel_rem;
    decel_rem_next = decel_rem;
    if (accel) begin
      accel_rem_next = rem100(rem_sum, step);
      ref_speed_next = (up_speed > 17'(target)) ? target : up_speed[SpeedW-1:0];
    end else if (decel) begin
      if (decel_rate == '0) begin
        ref_speed_next = target;
      end else begin
        decel_rem_next = rem100(rem_sum, step);
        if (SpeedW'(step) >= ref_speed || (ref_speed - SpeedW'(step)) < target) begin
          ref_speed_next = target;
        end else begin
          ref_speed_next = ref_speed - SpeedW'(step);
        end
      end
    end
  end

endmodule

// ----- hdl/msr_core.sv -----
// Mode machine, ramp state and stall counters; updated once per request.
// Depends on msr_pkg and msr_ramp.
`timescale 1ns / 1ps

module msr_core import msr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  cfg_t              cfg,
  input  logic [1:0]        work_state,
  input  logic [SpeedW-1:0] speed_setpoint,
  input  logic [SpeedW-1:0] feedback_speed,
  output res_t              res
);

  mode_t             mode, mode_next;
  logic [SpeedW-1:0] ref_speed, ref_speed_next;
  logic [RemW-1:0]   accel_rem, accel_rem_next;
  logic [RemW-1:0]   decel_rem, decel_rem_next;
  logic [SpeedW-1:0] stall_count, stall_count_next;
  logic [SpeedW-1:0] bounce_count, bounce_count_next;

  logic              halt;
  logic [SpeedW-1:0] target;
  logic [SpeedW-1:0] ramp_speed;
  logic [RemW-1:0]   ramp_accel_rem;
  logic [RemW-1:0]   ramp_decel_rem;
  logic              drive;
  logic              clr;
  logic              fault;

  assign halt   = (work_state == WS_IDLE) || (work_state == WS_STOP);
  assign target = halt ? '0 : speed_setpoint;

  msr_ramp u_ramp (
    .ref_speed      (ref_speed),
    .target         (target),
    .accel_rem      (accel_rem),
    .decel_rem      (decel_rem),
    .accel_rate     (cfg.accel_rate),
    .decel_rate     (cfg.decel_rate),
    .ref_speed_next (ramp_speed),
    .accel_rem_next (ramp_accel_rem),
    .decel_rem_next (ramp_decel_rem)
  );

  always_comb begin
    mode_next         = mode;
    ref_speed_next    = ref_speed;
    accel_rem_next    = accel_rem;
    decel_rem_next    = decel_rem;
    stall_count_next  = stall_count;
    bounce_count_next = bounce_count;
    drive             = 1'b0;
    clr               = 1'b0;
    fault             = 1'b0;
    case (mode)
      MODE_IDLE: begin
        if (!halt) begin
          mode_next = MODE_RUN;
          clr       = 1'b1;
          drive     = 1'b1;
        end
      end
      MODE_RUN: begin
        if (halt && ref_speed <= cfg.low_speed_limit) begin
          mode_next        = MODE_IDLE;
          ref_speed_next   = '0;
          accel_rem_next   = '0;
          decel_rem_next   = '0;
          stall_count_next = '0;
          clr              = 1'b1;
        end else begin
          drive          = 1'b1;
          ref_speed_next = ramp_speed;
          accel_rem_next = ramp_accel_rem;
          decel_rem_next = ramp_decel_rem;
          if (cfg.stall_check_enable) begin
            if (feedback_speed < cfg.low_speed_limit) begin
              if (stall_count < cfg.stall_timeout) begin
                stall_count_next = stall_count + 1'b1;
              end else begin
                stall_count_next = '0;
                mode_next        = MODE_ERR;
                fault            = 1'b1;
              end
              bounce_count_next = '0;
            end else if (bounce_count < cfg.bounce_timeout) begin
              bounce_count_next = bounce_count + 1'b1;
            end else begin
              bounce_count_next = '0;
              stall_count_next  = '0;
            end
          end
        end
      end
      default: begin
        clr = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (mode_next)
      MODE_IDLE: res.mode = MODE_CODE_IDLE;
      MODE_RUN:  res.mode = MODE_CODE_RUN;
      default:   res.mode = MODE_CODE_ERR;
    endcase
    res.reference_speed = ref_speed_next;
    res.drive_enable    = drive;
    res.regulator_clear = clr;
    res.stall_fault     = fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      ref_speed    <= '0;
      accel_rem    <= '0;
      decel_rem    <= '0;
      stall_count  <= '0;
      bounce_count <= '0;
    end else if (fire) begin
      mode         <= mode_next;
      ref_speed    <= ref_speed_next;
      accel_rem    <= accel_rem_next;
      decel_rem    <= decel_rem_next;
      stall_count  <= stall_count_next;
      bounce_count <= bounce_count_next;
    end
  end

endmodule

// ----- hdl/motor_speed_ramp_stall_guard.sv -----
// Top level: input register, config registers, core and result register.
// Depends on msr_pkg and msr_core.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   work_state, speed_setpoint, feedback_speed
//   out      out_valid / out_ready mode, reference_speed, drive_enable,
//                                  regulator_clear, stall_fault
//   cfg      cfg_we                cfg_index, cfg_data
//
// One request per cycle while out_ready holds; each result is registered.
// The ramp, mode machine and stall counters are combinational between the
// input register and the result register, with a reciprocal multiply for /100.
// Synchronous reset restores the register defaults and idle mode.
// A stalled output holds its result; an empty input register still takes one.
`timescale 1ns / 1ps

module motor_speed_ramp_stall_guard import msr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         work_state,
  input  logic [SpeedW-1:0]  speed_setpoint,
  input  logic [SpeedW-1:0]  feedback_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         mode,
  output logic [SpeedW-1:0]  reference_speed,
  output logic               drive_enable,
  output logic               regulator_clear,
  output logic               stall_fault,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [SpeedW-1:0]  cfg_data
);

  cfg_t              cfg;
  logic              req_valid;
  logic [1:0]        req_ws;
  logic [SpeedW-1:0] req_setpoint;
  logic [SpeedW-1:0] req_feedback;
  logic              advance;
  logic              fire;
  res_t              res;
  res_t              res_q;

  assign advance  = !out_valid || out_ready;
  assign fire     = req_valid && advance;
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_rate         <= 16'd100;
      cfg.decel_rate         <= 16'd100;
      cfg.low_speed_limit    <= 16'd50;
      cfg.stall_timeout      <= 16'd1000;
      cfg.bounce_timeout     <= 16'd100;
      cfg.stall_check_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_RATE:  cfg.accel_rate         <= cfg_data;
        CFG_DECEL_RATE:  cfg.decel_rate         <= cfg_data;
        CFG_LOW_LIMIT:   cfg.low_speed_limit    <= cfg_data;
        CFG_STALL_TIME:  cfg.stall_timeout      <= cfg_data;
        CFG_BOUNCE_TIME: cfg.bounce_timeout     <= cfg_data;
        CFG_STALL_EN:    cfg.stall_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_ws       <= work_state;
      req_setpoint <= speed_setpoint;
      req_feedback <= feedback_speed;
    end
  end

  msr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .cfg            (cfg),
    .work_state     (req_ws),
    .speed_setpoint (req_setpoint),
    .feedback_speed (req_feedback),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign mode            = res_q.mode;
  assign reference_speed = res_q.reference_speed;
  assign drive_enable    = res_q.drive_enable;
  assign regulator_clear = res_q.regulator_clear;
  assign stall_fault     = res_q.stall_fault;

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for motor_speed_ramp_stall_guard: directed ticks, then ramp/halt
// sequences over several register settings, with a final stall into error mode.
// Depends on msr_pkg and the RTL top; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench;
  import msr_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  class ramp_scoreboard;
    logic [SpeedW-1:0] accel_rate, decel_rate, low_limit, stall_limit, bounce_limit;
    logic              stall_en;
    logic [1:0]        mode_q;
    logic [SpeedW-1:0] ref_q;
    logic [RemW-1:0]   acc_rem, dec_rem;
    logic [SpeedW-1:0] stall_cnt, bounce_cnt;
    res_t              expected_q[$];
    int                mismatches;

    function new();
      accel_rate   = 16'd100;
      decel_rate   = 16'd100;
      low_limit    = 16'd50;
      stall_limit  = 16'd1000;
      bounce_limit = 16'd100;
      stall_en     = 1'b1;
      mode_q       = MODE_CODE_IDLE;
      ref_q        = '0;
      acc_rem      = '0;
      dec_rem      = '0;
      stall_cnt    = '0;
      bounce_cnt   = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [SpeedW-1:0] data);
      case (idx)
        CFG_ACCEL_RATE:  accel_rate   = data;
        CFG_DECEL_RATE:  decel_rate   = data;
        CFG_LOW_LIMIT:   low_limit    = data;
        CFG_STALL_TIME:  stall_limit  = data;
        CFG_BOUNCE_TIME: bounce_limit = data;
        CFG_STALL_EN:    stall_en     = data[0];
        default: ;
      endcase
    endfunction

    function void ramp_toward(logic [SpeedW-1:0] target);
      int unsigned total, step, nxt;
      if (target > ref_q) begin
        total   = acc_rem + accel_rate;
        step    = total / RampScale;
        acc_rem = RemW'(total % RampScale);
        nxt     = ref_q + step;
        ref_q   = (nxt > target) ? target : SpeedW'(nxt);
      end else if (target < ref_q) begin
        if (decel_rate == 0) begin
          ref_q = target;
        end else begin
          total   = dec_rem + decel_rate;
          step    = total / RampScale;
          dec_rem = RemW'(total % RampScale);
          if (step >= ref_q || ref_q - step < target) ref_q = target;
          else ref_q = SpeedW'(ref_q - step);
        end
      end
    endfunction

    function void note_request(logic [1:0] ws, logic [SpeedW-1:0] sp, logic [SpeedW-1:0] fb);
      res_t r;
      logic halt;
      halt = (ws == WS_IDLE) || (ws == WS_STOP);
      r = '0;
      case (mode_q)
        MODE_CODE_IDLE: begin
          if (!halt) begin
            mode_q            = MODE_CODE_RUN;
            r.regulator_clear = 1'b1;
            r.drive_enable    = 1'b1;
          end
        end
        MODE_CODE_RUN: begin
          if (halt && ref_q <= low_limit) begin
            ref_q             = '0;
            acc_rem           = '0;
            dec_rem           = '0;
            stall_cnt         = '0;
            mode_q            = MODE_CODE_IDLE;
            r.regulator_clear = 1'b1;
          end else begin
            r.drive_enable = 1'b1;
            ramp_toward(halt ? '0 : sp);
            if (stall_en) begin
              if (fb < low_limit) begin
                if (stall_cnt < stall_limit) begin
                  stall_cnt++;
                end else begin
                  stall_cnt     = '0;
                  mode_q        = MODE_CODE_ERR;
                  r.stall_fault = 1'b1;
                end
                bounce_cnt = '0;
              end else if (bounce_cnt < bounce_limit) begin
                bounce_cnt++;
              end else begin
                bounce_cnt = '0;
                stall_cnt  = '0;
              end
            end
          end
        end
        default: r.regulator_clear = 1'b1;
      endcase
      r.mode            = mode_q;
      r.reference_speed = ref_q;
      expected_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request: mode %0d ref %0d", $time, got.mode,
                   got.reference_speed);
        return;
      end
      want = expected_q.pop_front();
      if (got.mode !== want.mode || got.reference_speed !== want.reference_speed ||
          got.drive_enable !== want.drive_enable ||
          got.regulator_clear !== want.regulator_clear ||
          got.stall_fault !== want.stall_fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp mode %0d ref %0d drv %0b clr %0b flt %0b, ",
                    "got mode %0d ref %0d drv %0b clr %0b flt %0b"},
                   $time, want.mode, want.reference_speed, want.drive_enable,
                   want.regulator_clear, want.stall_fault, got.mode, got.reference_speed,
                   got.drive_enable, got.regulator_clear, got.stall_fault);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         work_state = '0;
  logic [SpeedW-1:0]  speed_setpoint = '0;
  logic [SpeedW-1:0]  feedback_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         mode;
  logic [SpeedW-1:0]  reference_speed;
  logic               drive_enable;
  logic               regulator_clear;
  logic               stall_fault;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SpeedW-1:0]  cfg_data = '0;

  bit calm = 1'b0;
  bit stall_allowed = 1'b0;
  ramp_scoreboard sb = new();

  motor_speed_ramp_stall_guard dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{mode: mode, reference_speed: reference_speed,
                        drive_enable: drive_enable, regulator_clear: regulator_clear,
                        stall_fault: stall_fault});
  end

  task automatic send_request(logic [1:0] ws, logic [SpeedW-1:0] sp, logic [SpeedW-1:0] fb);
    if (!stall_allowed && sb.mode_q == MODE_CODE_RUN && sb.stall_en &&
        sb.stall_cnt >= sb.stall_limit)
      fb = '1;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    work_state     <= ws;
    speed_setpoint <= sp;
    feedback_speed <= fb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(ws, sp, fb);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [SpeedW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(logic [SpeedW-1:0] accel, logic [SpeedW-1:0] decel,
                              logic [SpeedW-1:0] low, logic [SpeedW-1:0] stall_t,
                              logic [SpeedW-1:0] bounce_t, logic en);
    cfg_write(CFG_ACCEL_RATE, accel);
    cfg_write(CFG_DECEL_RATE, decel);
    cfg_write(CFG_LOW_LIMIT, low);
    cfg_write(CFG_STALL_TIME, stall_t);
    cfg_write(CFG_BOUNCE_TIME, bounce_t);
    cfg_write(CFG_STALL_EN, SpeedW'(en));
    cfg_write(CFG_SPARE_LO, SpeedW'($urandom));
    cfg_write(CFG_SPARE_HI, SpeedW'($urandom));
  endtask

  function automatic logic [SpeedW-1:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return SpeedW'($urandom);
      1: return SpeedW'($urandom_range(0, 255));
      2: return 16'hFFFF - SpeedW'($urandom_range(0, 255));
      default: return SpeedW'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic logic [SpeedW-1:0] pick_feedback();
    if ($urandom_range(0, 2) == 0) return SpeedW'($urandom_range(0, sb.low_limit));
    return SpeedW'($urandom);
  endfunction

  task automatic ramp_sequences(int n);
    int sent, len;
    logic [1:0] ws;
    logic [SpeedW-1:0] sp;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 70) begin
        ws  = $urandom_range(0, 1) ? WS_FORWARD : WS_REVERSE;
        sp  = pick_speed();
        len = $urandom_range(4, 40);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) sp = pick_speed();
          if ($urandom_range(0, 9) == 0) ws = (ws == WS_FORWARD) ? WS_REVERSE : WS_FORWARD;
          send_request(ws, sp, pick_feedback());
          sent++;
        end
        ws  = $urandom_range(0, 1) ? WS_IDLE : WS_STOP;
        len = 0;
        while (sb.mode_q == MODE_CODE_RUN && len < 60) begin
          send_request(ws, pick_speed(), pick_feedback());
          len++;
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_request(2'($urandom), SpeedW'($urandom), SpeedW'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int tries;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    program_regs(16'hFFFF, 16'd0, 16'd100, 16'd2, 16'd1, 1'b1);
    send_request(WS_IDLE, 16'hFFFF, 16'h0000);
    send_request(WS_STOP, 16'h0000, 16'hFFFF);
    repeat (4) send_request(WS_FORWARD, 16'hFFFF, 16'hFFFF);
    send_request(WS_REVERSE, 16'h0000, 16'hFFFF);
    send_request(WS_REVERSE, 16'd2000, 16'h0000);
    send_request(WS_FORWARD, 16'd2000, 16'd99);
    send_request(WS_FORWARD, 16'd2000, 16'd100);
    send_request(WS_STOP, 16'd2000, 16'd100);
    send_request(WS_STOP, 16'd2000, 16'd0);
    send_request(WS_IDLE, 16'd0, 16'd0);

    wait_drained();
    program_regs(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    repeat (3) send_request(WS_FORWARD, 16'd1, 16'd0);
    send_request(WS_STOP, 16'd0, 16'd0);

    wait_drained();
    program_regs(16'd250, 16'd1, 16'd3, 16'd1000, 16'd100, 1'b1);
    repeat (4) send_request(WS_FORWARD, 16'hFFFF, 16'hFFFF);
    repeat (3) send_request(WS_STOP, 16'h0000, 16'hFFFF);
    send_request(WS_REVERSE, 16'd5, 16'd2);

    wait_drained();
    program_regs(16'd250, 16'd180, 16'd50, 16'd20, 16'd5, 1'b1);
    ramp_sequences(200);

    wait_drained();
    program_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    ramp_sequences(200);

    wait_drained();
    program_regs(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    ramp_sequences(200);

    wait_drained();
    program_regs(SpeedW'($urandom_range(0, 3000)), SpeedW'($urandom_range(0, 3000)),
                 SpeedW'($urandom_range(0, 400)), SpeedW'($urandom_range(0, 50)),
                 SpeedW'($urandom_range(0, 20)), 1'b0);
    ramp_sequences(200);

    wait_drained();
    program_regs(16'd99, 16'd101, 16'd300, 16'd8, 16'd3, 1'b1);
    calm = 1'b1;
    ramp_sequences(200);
    calm = 1'b0;

    wait_drained();
    program_regs(SpeedW'($urandom), SpeedW'($urandom), SpeedW'($urandom),
                 SpeedW'($urandom), SpeedW'($urandom), 1'($urandom));
    ramp_sequences(200);

    wait_drained();
    program_regs(16'd733, 16'd0, 16'd1000, 16'd30, 16'd10, 1'b1);
    ramp_sequences(200);

    wait_drained();
    program_regs(16'd500, 16'd250, 16'd200, 16'd3, 16'd40, 1'b1);
    stall_allowed = 1'b1;
    repeat (6) send_request(WS_FORWARD, 16'd3000, 16'hFFFF);
    tries = 0;
    while (sb.mode_q != MODE_CODE_ERR && tries < 100) begin
      send_request(WS_FORWARD, 16'd3000, SpeedW'($urandom_range(0, 199)));
      tries++;
    end
    repeat (12) send_request(2'($urandom), SpeedW'($urandom), SpeedW'($urandom));

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
